### rtl/tsconv_pkg.sv
package tsconv_pkg;

	localparam int TS_W   = 64;
	localparam int STEP_W = 40;
	localparam int TICK_W = 32;
	localparam int CNT_W  = 6;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1000);
	localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(TS_W - 1);

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic add_rem;
		logic div_step;
		logic commit;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic started;
	} sts_t;

endpackage

### rtl/tsconv_dp.sv
module tsconv_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tsconv_pkg::cmd_t                  cmd,
	output tsconv_pkg::sts_t                  sts,
	input  logic [tsconv_pkg::TS_W-1:0]       timestamp,
	input  logic                              cfg_we,
	input  logic [tsconv_pkg::STEP_W-1:0]     cfg_step,
	output logic [tsconv_pkg::TICK_W-1:0]     tick_count
);

	logic [tsconv_pkg::STEP_W-1:0] step_q;
	logic                          started_q;
	logic [tsconv_pkg::TS_W-1:0]   anchor_q;
	logic [tsconv_pkg::STEP_W-1:0] rem_q;
	logic [tsconv_pkg::TICK_W-1:0] ticks_q;
	logic [tsconv_pkg::TS_W-1:0]   dvd_q;
	logic [tsconv_pkg::STEP_W-1:0] prem_q;
	logic [tsconv_pkg::TICK_W-1:0] out_q;

	logic [tsconv_pkg::STEP_W-1:0] divisor;
	logic [tsconv_pkg::STEP_W:0]   trial;
	logic [tsconv_pkg::STEP_W:0]   diff;
	logic                          qbit;

	// a zero step divides as one
	assign divisor = (step_q == '0) ? tsconv_pkg::STEP_W'(1) : step_q;
	assign trial   = {prem_q, dvd_q[tsconv_pkg::TS_W-1]};
	assign diff    = trial - {1'b0, divisor};
	assign qbit    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= tsconv_pkg::STEP_RESET;
			started_q <= 1'b0;
			anchor_q  <= '0;
			rem_q     <= '0;
			ticks_q   <= '0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_step;
			end
			if (cmd.accept) begin
				anchor_q <= timestamp;
				if (!started_q) begin
					started_q <= 1'b1;
					rem_q     <= '0;
					ticks_q   <= tsconv_pkg::TICK_W'(1);
				end
			end
			if (cmd.commit) begin
				rem_q   <= prem_q;
				ticks_q <= ticks_q + dvd_q[tsconv_pkg::TICK_W-1:0];
			end
		end
	end

	// restoring divider: dividend shifts out the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dvd_q  <= timestamp - anchor_q;
			prem_q <= '0;
		end else if (cmd.add_rem) begin
			dvd_q <= dvd_q + {{(tsconv_pkg::TS_W-tsconv_pkg::STEP_W){1'b0}}, rem_q};
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[tsconv_pkg::TS_W-2:0], qbit};
			prem_q <= qbit ? diff[tsconv_pkg::STEP_W-1:0] : trial[tsconv_pkg::STEP_W-1:0];
		end
		if (cmd.load_out) begin
			out_q <= ticks_q;
		end
	end

	assign sts.started = started_q;
	assign tick_count  = out_q;

endmodule

### rtl/tsconv_ctrl.sv
module tsconv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  tsconv_pkg::sts_t sts,
	output tsconv_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADD    = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_COMMIT = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]                   state_q;
	logic [2:0]                   state_d;
	logic [tsconv_pkg::CNT_W-1:0] cnt_q;
	logic                         out_valid_q;
	logic                         out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.started ? ST_ADD : ST_OUT;
				end
			end
			ST_ADD: begin
				cmd.add_rem = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == tsconv_pkg::CNT_LAST) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= cnt_q + tsconv_pkg::CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/timestamp_to_tick_converter_unit.sv
// Converts 64-bit timebase samples into a 32-bit tick count, one tick per
// step_counts timebase counts (reset value 1000; a step of 0 acts as 1). The
// first sample after reset sets the anchor and returns 1; each later sample
// adds (sample - anchor + carried remainder) / step to the count. A first
// sample goes straight to the output load; a later sample passes through the
// remainder add, the restoring divider that retires one quotient bit per
// cycle, the commit and the output load. The output load waits until the
// output register is free. One sample is in work at a time; a finished result
// waits in the output register while the next sample is taken. Step writes
// are always accepted and must be made while no sample is in work.
module timestamp_to_tick_converter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [tsconv_pkg::TS_W-1:0]       s_axis_tdata,  // [63:0] timestamp
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [tsconv_pkg::TICK_W-1:0]     m_axis_tdata,  // [31:0] tick_count
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsconv_pkg::STEP_W-1:0]     cfg_data
);

	tsconv_pkg::cmd_t cmd;
	tsconv_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tsconv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsconv_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.timestamp  (s_axis_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_step   (cfg_data),
		.tick_count (m_axis_tdata)
	);

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !s_axis_tready)
		else $error("input taken during division");

	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_axis_tvalid)
		else $error("loaded result not presented");

	a_commit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(cmd.div_step))
		else $error("commit without division");

	a_first_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !sts.started) |=> !cmd.add_rem && !cmd.div_step)
		else $error("first sample sent to divider");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int TS_W   = tsconv_pkg::TS_W;
	localparam int STEP_W = tsconv_pkg::STEP_W;
	localparam int TICK_W = tsconv_pkg::TICK_W;

	localparam logic [STEP_W-1:0] STEP_RESET = tsconv_pkg::STEP_RESET;

	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int SEGMENT_ITEMS = 115;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	localparam logic [TS_W-1:0]   TS_MAX   = '1;

	class tick_predictor;
		logic [STEP_W-1:0] step_cnt;
		bit                started;
		logic [TS_W-1:0]   anchor;
		logic [STEP_W-1:0] rem;
		logic [TICK_W-1:0] ticks;
		logic [TICK_W-1:0] expected_ticks[$];
		int                errors;

		function new();
			step_cnt = STEP_RESET;
			started  = 1'b0;
			anchor   = '0;
			rem      = '0;
			ticks    = '0;
			errors   = 0;
		endfunction

		function void set_step(logic [STEP_W-1:0] value);
			step_cnt = value;
		endfunction

		function void note_sample(logic [TS_W-1:0] ts);
			logic [TS_W-1:0] divisor;
			logic [TS_W-1:0] elapsed;
			logic [TS_W-1:0] quot;
			if (!started) begin
				started = 1'b1;
				anchor  = ts;
				rem     = '0;
				ticks   = TICK_W'(1);
			end else begin
				// a zero step divides as one
				divisor = (step_cnt == '0) ? TS_W'(1) : TS_W'(step_cnt);
				elapsed = (ts - anchor) + TS_W'(rem);
				quot    = elapsed / divisor;
				anchor  = ts;
				rem     = STEP_W'(elapsed - quot * divisor);
				ticks   = ticks + quot[TICK_W-1:0];
			end
			expected_ticks.push_back(ticks);
		endfunction

		function void check_tick(logic [TICK_W-1:0] actual);
			logic [TICK_W-1:0] want;
			if (expected_ticks.size() == 0) begin
				$display("%0t: unexpected tick_count transfer, expected none, actual %0d",
					$time, actual);
				errors++;
			end else begin
				want = expected_ticks.pop_front();
				if (actual !== want) begin
					$display("%0t: tick_count mismatch, expected %0d, actual %0d",
						$time, want, actual);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction
	endclass

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [TS_W-1:0]     s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TICK_W-1:0]   m_axis_tdata;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [STEP_W-1:0]   cfg_data      = '0;

	tick_predictor tick_model = new();
	int              tx_idle_pct = 12;
	int              rx_idle_pct = 82;
	int              idle_cycles = 0;
	logic [TS_W-1:0] last_ts     = '0;

	timestamp_to_tick_converter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [63:0] timestamp
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [31:0] tick_count
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			tick_model.check_tick(m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** timestamp_to_tick_converter_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_sample(input logic [TS_W-1:0] ts);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ts;
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready))
			@(posedge clk);
		tick_model.note_sample(ts);
		last_ts = ts;
	endtask

	// drain every pending tick before touching the step
	task automatic write_step(input logic [STEP_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (tick_model.pending() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready))
			@(posedge clk);
		tick_model.set_step(value);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [STEP_W-1:0] pick_step();
		logic [STEP_W-1:0] value;
		case ($urandom_range(5))
			0: value = '0;
			1: value = STEP_MAX;
			2: value = STEP_W'($urandom_range(1, 20));
			3: value = STEP_W'($urandom_range(1, 100000));
			4: value = STEP_W'({$urandom, $urandom});
			default: value = STEP_RESET;
		endcase
		return value;
	endfunction

	// mostly a forward-running timebase; some jumps anywhere and some steps back
	function automatic logic [TS_W-1:0] next_timestamp();
		logic [TS_W-1:0] ts;
		case ($urandom_range(19))
			0, 1: ts = {$urandom, $urandom};
			2: ts = last_ts - TS_W'($urandom_range(1, 5000));
			default: begin
				case ($urandom_range(3))
					0: ts = last_ts + TS_W'($urandom_range(0, 3000));
					1: ts = last_ts + TS_W'($urandom);
					2: ts = last_ts + ({$urandom, $urandom} >> $urandom_range(0, 63));
					default: ts = last_ts + TS_W'(tick_model.step_cnt) * $urandom_range(0, 8)
						+ TS_W'($urandom_range(0, 3));
				endcase
			end
		endcase
		return ts;
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset step: anchor, zero elapsed, carry, backwards and forward wrap
		send_sample(64'd100);
		send_sample(64'd100);
		send_sample(64'd2099);
		send_sample(64'd2100);
		send_sample(64'd0);
		send_sample(TS_MAX);
		send_sample(64'd0);

		// unit step: every count is a tick, quotient far beyond 32 bits
		write_step(STEP_W'(1));
		send_sample(64'd5);
		send_sample(64'h8000_0000_0000_0000);
		send_sample(64'h8000_0000_0000_0001);

		write_step(STEP_MAX);
		send_sample(64'h8000_00FF_FFFF_FFFF);
		send_sample(64'h8000_0100_0000_0002);
		send_sample(TS_MAX);

		// zero step with a carried remainder from the wide step
		write_step('0);
		send_sample(64'h0000_0000_0000_1234);
		send_sample(64'h0000_0000_0000_1234);

		write_step(STEP_W'(7));
		send_sample(64'h0000_0000_0000_1240);
		send_sample(64'hFFFF_FFFF_FFFF_FFF0);

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin tx_idle_pct = 12; rx_idle_pct = 82; end
				1: begin tx_idle_pct = 82; rx_idle_pct = 12; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				write_step(pick_step());
				repeat (SEGMENT_ITEMS)
					send_sample(next_timestamp());
			end
		end
		s_axis_tvalid <= 1'b0;

		while (tick_model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tick_model.errors == 0)
			$display("** timestamp_to_tick_converter_unit: PASSED **");
		else
			$display("** timestamp_to_tick_converter_unit: FAILED **");
		$finish;
	end

endmodule

### sim.f
rtl/tsconv_pkg.sv
rtl/tsconv_dp.sv
rtl/tsconv_ctrl.sv
rtl/timestamp_to_tick_converter_unit.sv
tb/tb_top.sv
